### hw/rtl/ppps_pkg.sv
// ppps_pkg: widths, fixed-point constants and shared types of the pentagon prism
// point select block. No dependencies; every other file imports it.

package ppps_pkg;

  // coordinate and trig formats
  localparam int COORD_BITS = 20;
  localparam int TRIG_BITS  = 16;
  localparam int TRIG_FRAC  = TRIG_BITS - 2;
  localparam int TRIG_ONE   = 1 << TRIG_FRAC;
  localparam int ROUND_HALF = 1 << (TRIG_FRAC - 1);
  localparam int KIND_BITS  = 16;

  // pentagon shape constants, Q1.12
  localparam int KFRAC = 12;
  localparam int KD    = 3484;
  localparam int KS1   = 1331;
  localparam int KS2   = 5638;
  localparam int K54   = 3314;
  localparam int K72   = 1266;

  // side length multipliers for the derived lengths, scale 2^24
  localparam int K_DSIN  = KD * K54;
  localparam int K_DCOS  = KD * K72;
  localparam int K_DLEN  = KD << KFRAC;
  localparam int K_ICPT1 = KD * KD;
  localparam int K_ICPT2 = KD * KS2;

  // configuration port
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 64;
  localparam int CENTRE_W      = 3 * COORD_BITS;
  localparam int TRIG_PAIR_W   = 2 * TRIG_BITS;
  localparam int TYPE_SEL_W    = 2 * KIND_BITS;

  // pipeline depth
  localparam int NSTAGE = 5;

  // datapath widths
  localparam int OFS_W    = COORD_BITS + 1;
  localparam int SQF_W    = 2 * OFS_W;
  localparam int SQ_W     = 2 * COORD_BITS;
  localparam int RSQ_W    = SQ_W + 2;
  localparam int TPROD_W  = 2 * TRIG_BITS;
  localparam int MAT_W    = TPROD_W - TRIG_FRAC;
  localparam int MD_W     = MAT_W + OFS_W;
  localparam int TD_W     = TRIG_BITS + OFS_W;
  localparam int SUM_W    = MD_W + 2;
  localparam int ROT_W    = SUM_W - TRIG_FRAC;
  localparam int KS_W     = KFRAC + 2;
  localparam int KSY_W    = ROT_W + KS_W;
  localparam int SIDE_K_W = COORD_BITS + 2 * KFRAC + 1;
  localparam int CMP_W    = ROT_W + 2 * KFRAC + 1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CENTRE,
    REG_BOUND_SQ,
    REG_SIDE,
    REG_HALF_THICK,
    REG_POLAR,
    REG_AZIMUTH,
    REG_TYPE_SEL
  } ppps_reg_e;

  typedef struct packed {
    logic        [COORD_BITS-1:0] centre_x;
    logic        [COORD_BITS-1:0] centre_y;
    logic        [COORD_BITS-1:0] centre_z;
    logic        [SQ_W-1:0]       bound_sq;
    logic        [COORD_BITS-1:0] side;
    logic        [COORD_BITS-1:0] half_thick;
    logic signed [TRIG_BITS-1:0]  cos_theta;
    logic signed [TRIG_BITS-1:0]  sin_theta;
    logic signed [TRIG_BITS-1:0]  cos_phi;
    logic signed [TRIG_BITS-1:0]  sin_phi;
    logic        [KIND_BITS-1:0]  polymer_sel;
    logic        [KIND_BITS-1:0]  head_sel;
  } ppps_cfg_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic [COORD_BITS-1:0] pos_z;
    logic [KIND_BITS-1:0]  polymer_kind;
    logic [KIND_BITS-1:0]  head_kind;
    logic                  head_present;
  } ppps_item_t;

  typedef struct packed {
    logic selected;
    logic in_sphere;
  } ppps_result_t;

  typedef struct packed {
    logic [NSTAGE-1:0] load;
  } ppps_stage_ctl_t;

endpackage

### hw/rtl/ppps_if.sv
// ppps_if: valid/ready channel interfaces for particles, results and config writes.
// Depends on ppps_pkg for field widths.

// particle channel
interface ppps_in_if import ppps_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pos_x;
  logic [COORD_BITS-1:0] pos_y;
  logic [COORD_BITS-1:0] pos_z;
  logic [KIND_BITS-1:0]  polymer_kind;
  logic [KIND_BITS-1:0]  head_kind;
  logic                  head_present;

  modport source (output valid, pos_x, pos_y, pos_z, polymer_kind, head_kind, head_present,
                  input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, polymer_kind, head_kind, head_present,
                output ready);
endinterface

// result channel
interface ppps_out_if import ppps_pkg::*; ();
  logic valid;
  logic ready;
  logic selected;
  logic in_sphere;

  modport source (output valid, selected, in_sphere, input ready);
  modport sink (input valid, selected, in_sphere, output ready);
endinterface

// configuration write channel
interface ppps_cfg_if import ppps_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/ppps_cfg_regs.sv
// ppps_cfg_regs: configuration register file, always ready for a write transaction.
// Depends on ppps_pkg and the ppps_cfg_if interface.

module ppps_cfg_regs import ppps_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ppps_cfg_if.sink   cfg_i,
  output ppps_cfg_t  cfg_o
);

  logic [CENTRE_W-1:0]    centre_q;
  logic [SQ_W-1:0]        bound_q;
  logic [COORD_BITS-1:0]  side_q;
  logic [COORD_BITS-1:0]  half_q;
  logic [TRIG_PAIR_W-1:0] polar_q;
  logic [TRIG_PAIR_W-1:0] azimuth_q;
  logic [TYPE_SEL_W-1:0]  type_q;

  assign cfg_i.ready = 1'b1;

  // register writes, bits above each register's width are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      centre_q  <= '0;
      bound_q   <= '0;
      side_q    <= '0;
      half_q    <= '0;
      polar_q   <= {TRIG_BITS'(TRIG_ONE), TRIG_BITS'(0)};
      azimuth_q <= {TRIG_BITS'(TRIG_ONE), TRIG_BITS'(0)};
      type_q    <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_CENTRE:     centre_q  <= CENTRE_W'(cfg_i.data);
        REG_BOUND_SQ:   bound_q   <= SQ_W'(cfg_i.data);
        REG_SIDE:       side_q    <= COORD_BITS'(cfg_i.data);
        REG_HALF_THICK: half_q    <= COORD_BITS'(cfg_i.data);
        REG_POLAR:      polar_q   <= TRIG_PAIR_W'(cfg_i.data);
        REG_AZIMUTH:    azimuth_q <= TRIG_PAIR_W'(cfg_i.data);
        REG_TYPE_SEL:   type_q    <= TYPE_SEL_W'(cfg_i.data);
        default: ;
      endcase
    end
  end

  // unpack into named fields
  assign cfg_o.centre_x    = centre_q[COORD_BITS-1:0];
  assign cfg_o.centre_y    = centre_q[2*COORD_BITS-1:COORD_BITS];
  assign cfg_o.centre_z    = centre_q[3*COORD_BITS-1:2*COORD_BITS];
  assign cfg_o.bound_sq    = bound_q;
  assign cfg_o.side        = side_q;
  assign cfg_o.half_thick  = half_q;
  assign cfg_o.cos_theta   = $signed(polar_q[TRIG_PAIR_W-1:TRIG_BITS]);
  assign cfg_o.sin_theta   = $signed(polar_q[TRIG_BITS-1:0]);
  assign cfg_o.cos_phi     = $signed(azimuth_q[TRIG_PAIR_W-1:TRIG_BITS]);
  assign cfg_o.sin_phi     = $signed(azimuth_q[TRIG_BITS-1:0]);
  assign cfg_o.polymer_sel = type_q[TYPE_SEL_W-1:KIND_BITS];
  assign cfg_o.head_sel    = type_q[KIND_BITS-1:0];

endmodule

### hw/rtl/ppps_datapath.sv
// ppps_datapath: five payload stages of the point select (offset, square and rotate,
// sphere test, rotated point, slab test). Depends on ppps_pkg; load enables come from top.

module ppps_datapath import ppps_pkg::*; (
  input  logic            clk_i,
  input  ppps_cfg_t       cfg_i,
  input  ppps_item_t      item_i,
  input  ppps_stage_ctl_t ctl_i,
  output ppps_result_t    res_o
);

  // round a trig product back to trig format, half up
  function automatic logic signed [MAT_W-1:0] round_trig(input logic signed [TPROD_W-1:0] p);
    logic signed [TPROD_W-1:0] h;
    h = p + TPROD_W'(ROUND_HALF);
    return MAT_W'(h >>> TRIG_FRAC);
  endfunction

  // round a rotated sum to whole coordinate units, half up
  function automatic logic signed [ROT_W-1:0] round_sum(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] h;
    h = s + SUM_W'(ROUND_HALF);
    return ROT_W'(h >>> TRIG_FRAC);
  endfunction

  function automatic logic [SQ_W-1:0] square(input logic signed [OFS_W-1:0] d);
    logic signed [SQF_W-1:0] w;
    w = SQF_W'(d) * SQF_W'(d);
    return SQ_W'(w);
  endfunction

  function automatic logic [ROT_W-1:0] magnitude(input logic signed [ROT_W-1:0] v);
    logic signed [ROT_W-1:0] n;
    n = -v;
    return v[ROT_W-1] ? ROT_W'(n) : ROT_W'(v);
  endfunction

  // stage 1: offsets, type match, trig products
  logic signed [OFS_W-1:0]   s1_dx_d, s1_dy_d, s1_dz_d, s1_dx_q, s1_dy_q, s1_dz_q;
  logic signed [TPROD_W-1:0] s1_p00_d, s1_p01_d, s1_p20_d, s1_p21_d;
  logic signed [TPROD_W-1:0] s1_p00_q, s1_p01_q, s1_p20_q, s1_p21_q;
  logic                      s1_ok_d, s1_ok_q;

  assign s1_dx_d  = $signed({1'b0, item_i.pos_x}) - $signed({1'b0, cfg_i.centre_x});
  assign s1_dy_d  = $signed({1'b0, item_i.pos_y}) - $signed({1'b0, cfg_i.centre_y});
  assign s1_dz_d  = $signed({1'b0, item_i.pos_z}) - $signed({1'b0, cfg_i.centre_z});
  assign s1_p00_d = TPROD_W'(cfg_i.cos_theta) * TPROD_W'(cfg_i.cos_phi);
  assign s1_p01_d = TPROD_W'(cfg_i.cos_theta) * TPROD_W'(cfg_i.sin_phi);
  assign s1_p20_d = TPROD_W'(cfg_i.sin_theta) * TPROD_W'(cfg_i.cos_phi);
  assign s1_p21_d = TPROD_W'(cfg_i.sin_theta) * TPROD_W'(cfg_i.sin_phi);
  assign s1_ok_d  = item_i.head_present && (item_i.polymer_kind == cfg_i.polymer_sel) &&
                    (item_i.head_kind == cfg_i.head_sel);

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[0]) begin
      s1_dx_q  <= s1_dx_d;
      s1_dy_q  <= s1_dy_d;
      s1_dz_q  <= s1_dz_d;
      s1_p00_q <= s1_p00_d;
      s1_p01_q <= s1_p01_d;
      s1_p20_q <= s1_p20_d;
      s1_p21_q <= s1_p21_d;
      s1_ok_q  <= s1_ok_d;
    end
  end

  // stage 2: squares, rounded matrix entries, single trig-by-offset products
  logic        [SQ_W-1:0]  s2_sqx_d, s2_sqy_d, s2_sqz_d, s2_sqx_q, s2_sqy_q, s2_sqz_q;
  logic signed [MAT_W-1:0] s2_m00_d, s2_m01_d, s2_m20_d, s2_m21_d;
  logic signed [MAT_W-1:0] s2_m00_q, s2_m01_q, s2_m20_q, s2_m21_q;
  logic signed [TD_W-1:0]  s2_psx_d, s2_pcy_d, s2_pstz_d, s2_pctz_d;
  logic signed [TD_W-1:0]  s2_psx_q, s2_pcy_q, s2_pstz_q, s2_pctz_q;
  logic signed [OFS_W-1:0] s2_dx_q, s2_dy_q;
  logic                    s2_ok_q;

  assign s2_sqx_d  = square(s1_dx_q);
  assign s2_sqy_d  = square(s1_dy_q);
  assign s2_sqz_d  = square(s1_dz_q);
  assign s2_m00_d  = round_trig(s1_p00_q);
  assign s2_m01_d  = round_trig(s1_p01_q);
  assign s2_m20_d  = round_trig(s1_p20_q);
  assign s2_m21_d  = round_trig(s1_p21_q);
  assign s2_psx_d  = TD_W'(cfg_i.sin_phi) * TD_W'(s1_dx_q);
  assign s2_pcy_d  = TD_W'(cfg_i.cos_phi) * TD_W'(s1_dy_q);
  assign s2_pstz_d = TD_W'(cfg_i.sin_theta) * TD_W'(s1_dz_q);
  assign s2_pctz_d = TD_W'(cfg_i.cos_theta) * TD_W'(s1_dz_q);

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[1]) begin
      s2_sqx_q  <= s2_sqx_d;
      s2_sqy_q  <= s2_sqy_d;
      s2_sqz_q  <= s2_sqz_d;
      s2_m00_q  <= s2_m00_d;
      s2_m01_q  <= s2_m01_d;
      s2_m20_q  <= s2_m20_d;
      s2_m21_q  <= s2_m21_d;
      s2_psx_q  <= s2_psx_d;
      s2_pcy_q  <= s2_pcy_d;
      s2_pstz_q <= s2_pstz_d;
      s2_pctz_q <= s2_pctz_d;
      s2_dx_q   <= s1_dx_q;
      s2_dy_q   <= s1_dy_q;
      s2_ok_q   <= s1_ok_q;
    end
  end

  // stage 3: sphere test, matrix-by-offset products, rotated y
  logic        [RSQ_W-1:0] s3_rsq;
  logic                    s3_sphere_d, s3_sphere_q;
  logic signed [MD_W-1:0]  s3_q00_d, s3_q01_d, s3_q20_d, s3_q21_d;
  logic signed [MD_W-1:0]  s3_q00_q, s3_q01_q, s3_q20_q, s3_q21_q;
  logic signed [ROT_W-1:0] s3_ry_d, s3_ry_q;
  logic signed [TD_W-1:0]  s3_pstz_q, s3_pctz_q;

  assign s3_rsq      = RSQ_W'(s2_sqx_q) + RSQ_W'(s2_sqy_q) + RSQ_W'(s2_sqz_q);
  assign s3_sphere_d = s2_ok_q && (s3_rsq < RSQ_W'(cfg_i.bound_sq));
  assign s3_q00_d    = MD_W'(s2_m00_q) * MD_W'(s2_dx_q);
  assign s3_q01_d    = MD_W'(s2_m01_q) * MD_W'(s2_dy_q);
  assign s3_q20_d    = MD_W'(s2_m20_q) * MD_W'(s2_dx_q);
  assign s3_q21_d    = MD_W'(s2_m21_q) * MD_W'(s2_dy_q);
  assign s3_ry_d     = round_sum(SUM_W'(s2_pcy_q) - SUM_W'(s2_psx_q));

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[2]) begin
      s3_sphere_q <= s3_sphere_d;
      s3_q00_q    <= s3_q00_d;
      s3_q01_q    <= s3_q01_d;
      s3_q20_q    <= s3_q20_d;
      s3_q21_q    <= s3_q21_d;
      s3_ry_q     <= s3_ry_d;
      s3_pstz_q   <= s2_pstz_q;
      s3_pctz_q   <= s2_pctz_q;
    end
  end

  // stage 4: rotated x and z, slope terms, pentagon lengths from the side length
  logic signed [ROT_W-1:0]    s4_rx, s4_rz, s4_ry_q;
  logic        [ROT_W-1:0]    s4_ax_d, s4_az_d, s4_ax_q, s4_az_q;
  logic signed [KSY_W-1:0]    s4_ks1y_d, s4_ks2y_d, s4_ks1y_q, s4_ks2y_q;
  logic        [SIDE_K_W-1:0] s4_dsin_d, s4_dcos_d, s4_dlen_d, s4_icpt1_d, s4_icpt2_d;
  logic        [SIDE_K_W-1:0] s4_dsin_q, s4_dcos_q, s4_dlen_q, s4_icpt1_q, s4_icpt2_q;
  logic                       s4_sphere_q;

  assign s4_rx      = round_sum(SUM_W'(s3_q00_q) + SUM_W'(s3_q01_q) - SUM_W'(s3_pstz_q));
  assign s4_rz      = round_sum(SUM_W'(s3_q20_q) + SUM_W'(s3_q21_q) + SUM_W'(s3_pctz_q));
  assign s4_ax_d    = magnitude(s4_rx);
  assign s4_az_d    = magnitude(s4_rz);
  assign s4_ks1y_d  = KSY_W'(s3_ry_q) * KSY_W'(KS1);
  assign s4_ks2y_d  = KSY_W'(s3_ry_q) * KSY_W'(KS2);
  assign s4_dsin_d  = SIDE_K_W'(cfg_i.side) * SIDE_K_W'(K_DSIN);
  assign s4_dcos_d  = SIDE_K_W'(cfg_i.side) * SIDE_K_W'(K_DCOS);
  assign s4_dlen_d  = SIDE_K_W'(cfg_i.side) * SIDE_K_W'(K_DLEN);
  assign s4_icpt1_d = SIDE_K_W'(cfg_i.side) * SIDE_K_W'(K_ICPT1);
  assign s4_icpt2_d = SIDE_K_W'(cfg_i.side) * SIDE_K_W'(K_ICPT2);

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[3]) begin
      s4_ax_q     <= s4_ax_d;
      s4_az_q     <= s4_az_d;
      s4_ry_q     <= s3_ry_q;
      s4_ks1y_q   <= s4_ks1y_d;
      s4_ks2y_q   <= s4_ks2y_d;
      s4_dsin_q   <= s4_dsin_d;
      s4_dcos_q   <= s4_dcos_d;
      s4_dlen_q   <= s4_dlen_d;
      s4_icpt1_q  <= s4_icpt1_d;
      s4_icpt2_q  <= s4_icpt2_d;
      s4_sphere_q <= s3_sphere_q;
    end
  end

  // stage 5: slab test at scale 2^24 into the output register
  logic signed [CMP_W-1:0] y24, x24, dsin, dcos, dlen, lim1, lim2;
  logic                    thick_ok, band1, band2, slab;
  logic                    s5_sel_d, s5_sel_q, s5_sphere_q;

  always_comb begin
    y24      = CMP_W'(s4_ry_q) <<< (2 * KFRAC);
    x24      = $signed(CMP_W'(s4_ax_q)) <<< (2 * KFRAC);
    dsin     = $signed(CMP_W'(s4_dsin_q));
    dcos     = $signed(CMP_W'(s4_dcos_q));
    dlen     = $signed(CMP_W'(s4_dlen_q));
    lim1     = (CMP_W'(s4_ks1y_q) <<< KFRAC) + $signed(CMP_W'(s4_icpt1_q));
    lim2     = $signed(CMP_W'(s4_icpt2_q)) - (CMP_W'(s4_ks2y_q) <<< KFRAC);
    thick_ok = s4_az_q < ROT_W'(cfg_i.half_thick);
    // lower band up to the widest row, upper band toward the apex
    band1    = (y24 > -dsin) && (y24 < dcos) && (x24 < lim1);
    band2    = (y24 > dcos) && (y24 < dlen) && (x24 < lim2);
    slab     = thick_ok && (band1 || band2);
    s5_sel_d = s4_sphere_q && slab;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[4]) begin
      s5_sel_q    <= s5_sel_d;
      s5_sphere_q <= s4_sphere_q;
    end
  end

  assign res_o.selected  = s5_sel_q;
  assign res_o.in_sphere = s5_sphere_q;

endmodule

### hw/rtl/pentagon_prism_point_select.sv
// pentagon_prism_point_select: top level, stage valid chain and channel wiring.
// Depends on ppps_pkg, ppps_if, ppps_cfg_regs and ppps_datapath.
//
// Usage:
//   in_i carries one particle per transaction: head position, polymer type,
//   head bead type and a head-present flag. out_o returns one result per
//   particle, in order: selected (inside the rotated pentagonal slab) and
//   in_sphere (head present, types match, inside the bounding sphere).
//   cfg_i writes one register per transaction (index, data); it is always
//   ready. Write it only while no particle is in flight.
// Pipeline and throughput:
//   five register stages; out_o.valid is the valid bit of the last stage,
//   which holds the result. One particle per cycle is accepted while out_o
//   drains.
// Reset:
//   all stage valid bits clear, configuration registers return to their
//   defaults (rotation identity, everything else zero).
// Stall:
//   when out_o.ready is low the output holds; upstream stages keep filling
//   empty slots, and in_i.ready drops once every stage holds a particle.

module pentagon_prism_point_select import ppps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ppps_cfg_if.sink    cfg_i,
  ppps_in_if.sink     in_i,
  ppps_out_if.source  out_o
);

  ppps_cfg_t       cfg;
  ppps_item_t      item;
  ppps_result_t    res;
  ppps_stage_ctl_t ctl;

  logic [NSTAGE-1:0] valid_d, valid_q;
  logic [NSTAGE-1:0] feed;
  logic [NSTAGE:0]   ready;

  ppps_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // pack the particle transaction
  assign item.pos_x        = in_i.pos_x;
  assign item.pos_y        = in_i.pos_y;
  assign item.pos_z        = in_i.pos_z;
  assign item.polymer_kind = in_i.polymer_kind;
  assign item.head_kind    = in_i.head_kind;
  assign item.head_present = in_i.head_present;

  // a stage can take data when it is empty or its content moves on
  always_comb begin
    ready[NSTAGE] = out_o.ready;
    for (int k = NSTAGE - 1; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
    feed     = {valid_q[NSTAGE-2:0], in_i.valid};
    ctl.load = ready[NSTAGE-1:0] & feed;
    valid_d  = ctl.load | (~ready[NSTAGE-1:0] & valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  ppps_datapath u_datapath (
    .clk_i  (clk_i),
    .cfg_i  (cfg),
    .item_i (item),
    .ctl_i  (ctl),
    .res_o  (res)
  );

  assign in_i.ready      = ready[0];
  assign out_o.valid     = valid_q[NSTAGE-1];
  assign out_o.selected  = res.selected;
  assign out_o.in_sphere = res.in_sphere;

endmodule

### hw/rtl/ppps_checker.sv
// ppps_checker: port-level assertions for the point select, bound to the top level.
// Depends on ppps_pkg and pentagon_prism_point_select.

module ppps_checker import ppps_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic selected_i,
  input logic in_sphere_i
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(selected_i) && $stable(in_sphere_i))
    else $error("result changed while stalled");

  // slab membership implies the sphere test passed
  a_sel_in_sphere: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && selected_i |-> in_sphere_i)
    else $error("selected without in_sphere");

  // a result after an empty output comes from an accepted input transaction
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, NSTAGE))
    else $error("result appeared without matching input transaction");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_i)
    else $error("result valid right after reset");

endmodule

bind pentagon_prism_point_select ppps_checker u_ppps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .selected_i  (out_o.selected),
  .in_sphere_i (out_o.in_sphere)
);
